FILE: src/cpt_pkg.sv
package cpt_pkg;

	// Region codes as shown on the region port
	typedef enum logic [2:0] {
		REG_VERT_A   = 3'd0,
		REG_VERT_B   = 3'd1,
		REG_EDGE_AB  = 3'd2,
		REG_VERT_C   = 3'd3,
		REG_EDGE_AC  = 3'd4,
		REG_EDGE_BC  = 3'd5,
		REG_INTERIOR = 3'd6
	} region_t;

	// Cycles from an accepted start to its done strobe
	function automatic int pipe_latency(input int coord_bits);
		return coord_bits + 20;
	endfunction

endpackage

FILE: src/cpt_dly.sv
module cpt_dly #(
	parameter int W = 8,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] sr_q [N];

	// Shift the payload one stage per cycle
	always_ff @(posedge clk) begin
		sr_q[0] <= d;
		for (int i = 1; i < N; i++) begin
			sr_q[i] <= sr_q[i-1];
		end
	end

	assign q = sr_q[N-1];

endmodule

FILE: src/cpt_mul.sv
module cpt_mul #(
	parameter int WA = 32,
	parameter int WB = 32
) (
	input  logic                    clk,
	input  logic signed [WA-1:0]    a,
	input  logic signed [WB-1:0]    b,
	output logic signed [WA+WB-1:0] p
);

	localparam int C    = 26;
	localparam int NA   = (WA + C - 1) / C;
	localparam int NB   = (WB + C - 1) / C;
	localparam int PW   = WA + WB;
	localparam int ACCW = (NA + NB) * C;

	logic [WA-1:0]     aa;
	logic [WB-1:0]     bb;
	logic [NA*C-1:0]   ma_s1;
	logic [NB*C-1:0]   mb_s1;
	logic              neg_s1, neg_s2, neg_s3;
	logic [2*C-1:0]    pp_s2 [NA*NB];
	logic [ACCW-1:0]   acc;
	logic [PW-1:0]     sum_s3;

	assign aa = a[WA-1] ? WA'(-a) : WA'(a);
	assign bb = b[WB-1] ? WB'(-b) : WB'(b);

	// Stage 1: split into magnitudes and sign
	always_ff @(posedge clk) begin
		ma_s1  <= (NA*C)'(aa);
		mb_s1  <= (NB*C)'(bb);
		neg_s1 <= a[WA-1] ^ b[WB-1];
	end

	// Stage 2: narrow partial products
	always_ff @(posedge clk) begin
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NB; j++) begin
				pp_s2[i*NB+j] <= ma_s1[i*C +: C] * mb_s1[j*C +: C];
			end
		end
		neg_s2 <= neg_s1;
	end

	// Stage 3: add the shifted partials
	always_comb begin
		acc = '0;
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NB; j++) begin
				acc = acc + (ACCW'(pp_s2[i*NB+j]) << ((i + j) * C));
			end
		end
	end

	always_ff @(posedge clk) begin
		sum_s3 <= acc[PW-1:0];
		neg_s3 <= neg_s2;
	end

	// Stage 4: restore the sign
	always_ff @(posedge clk) begin
		p <= neg_s3 ? -$signed(sum_s3) : $signed(sum_s3);
	end

endmodule

FILE: src/cpt_div.sv
module cpt_div #(
	parameter int NW = 64,
	parameter int DW = 64,
	parameter int QB = 26
) (
	input  logic                 clk,
	input  logic signed [NW-1:0] n,
	input  logic signed [DW-1:0] d,
	output logic signed [QB:0]   q
);

	localparam int RW = ((NW > DW) ? NW : DW) + QB;

	logic [NW-1:0] na;
	logic [DW-1:0] da;
	logic [RW-1:0] nm_s1, dm_s1;
	logic          neg_s1;

	// One remainder stage per quotient bit; entry 0 is the overflow stage
	logic [RW-1:0] rem_sk [QB];
	logic [RW-1:0] dm_sk  [QB];
	logic [QB-1:0] qb_sk  [QB];
	logic          neg_sk [QB];
	logic          ovf_sk [QB];
	logic [QB-1:0] mag;

	assign na = n[NW-1] ? NW'(-n) : NW'(n);
	assign da = d[DW-1] ? DW'(-d) : DW'(d);

	// Take magnitudes
	always_ff @(posedge clk) begin
		nm_s1  <= RW'(na);
		dm_s1  <= RW'(da);
		neg_s1 <= n[NW-1] ^ d[DW-1];
	end

	// Flag quotients too large to matter after saturation
	always_ff @(posedge clk) begin
		ovf_sk[0] <= nm_s1 >= (dm_s1 << (QB - 1));
		rem_sk[0] <= nm_s1;
		dm_sk[0]  <= dm_s1;
		qb_sk[0]  <= '0;
		neg_sk[0] <= neg_s1;
	end

	// Restoring division, one bit per stage from the top
	for (genvar k = 0; k < QB - 1; k++) begin : g_bit
		localparam int BI = QB - 2 - k;
		logic [RW-1:0] sh;
		assign sh = dm_sk[k] << BI;
		always_ff @(posedge clk) begin
			if (rem_sk[k] >= sh) begin
				rem_sk[k+1] <= rem_sk[k] - sh;
				qb_sk[k+1]  <= qb_sk[k] | (QB'(1) << BI);
			end else begin
				rem_sk[k+1] <= rem_sk[k];
				qb_sk[k+1]  <= qb_sk[k];
			end
			dm_sk[k+1]  <= dm_sk[k];
			neg_sk[k+1] <= neg_sk[k];
			ovf_sk[k+1] <= ovf_sk[k];
		end
	end

	assign mag = ovf_sk[QB-1] ? (QB'(1) << (QB - 1)) : qb_sk[QB-1];

	// Apply the sign, truncating toward zero
	always_ff @(posedge clk) begin
		q <= neg_sk[QB-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	end

endmodule

FILE: src/closest_point_on_triangle_unit.sv
// Closest point on triangle p, corners a/b/c (signed fixed point). Pulse start
// with the coordinates; busy stays low, so a new query may be issued every
// cycle. Each query yields one done pulse, in issue order, carrying near_x/y/z,
// region and degenerate. The receiver must take the beat in that cycle. The
// pipeline runs the dot product, cross product and numerator multiplier stages,
// then a divider that resolves one quotient bit per stage.
module closest_point_on_triangle_unit #(
	parameter int COORD_BITS = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	input  logic signed [COORD_BITS-1:0] point_z,
	input  logic signed [COORD_BITS-1:0] corner_a_x,
	input  logic signed [COORD_BITS-1:0] corner_a_y,
	input  logic signed [COORD_BITS-1:0] corner_a_z,
	input  logic signed [COORD_BITS-1:0] corner_b_x,
	input  logic signed [COORD_BITS-1:0] corner_b_y,
	input  logic signed [COORD_BITS-1:0] corner_b_z,
	input  logic signed [COORD_BITS-1:0] corner_c_x,
	input  logic signed [COORD_BITS-1:0] corner_c_y,
	input  logic signed [COORD_BITS-1:0] corner_c_z,
	output logic                         done,
	output logic signed [COORD_BITS-1:0] near_x,
	output logic signed [COORD_BITS-1:0] near_y,
	output logic signed [COORD_BITS-1:0] near_z,
	output logic [2:0]                   region,
	output logic                         degenerate
);

	localparam int CB   = COORD_BITS;
	localparam int DIFF = CB + 1;
	localparam int DOTW = 2 * DIFF + 2;
	localparam int VW   = 2 * DOTW + 1;
	localparam int DENW = VW + 2;
	localparam int NUMW = DIFF + VW + 1;
	localparam int QB   = CB + 2;
	localparam int L    = QB + 2;
	localparam int LAT  = cpt_pkg::pipe_latency(CB);
	localparam int SW   = CB + 4;
	localparam logic signed [SW-1:0] MAXV = (SW'(1) << (CB - 1)) - SW'(1);
	localparam logic signed [SW-1:0] MINV = -MAXV - SW'(1);

	logic [LAT-1:0] vld_q;

	logic [2:0][CB-1:0]         pt_s1, ca_s1, cb_s1, cc_s1;
	logic [1:0][2:0][DIFF-1:0]  edge_s2;
	logic [2:0][2:0][DIFF-1:0]  pv_s2;
	logic [2:0][DIFF-1:0]       bc_s2;
	logic [5:0][2:0][2*DIFF-1:0] prod_s3;
	logic [5:0][DOTW-1:0]       dot_s4;
	logic signed [2*DOTW-1:0]   m_s8 [6];
	logic signed [VW-1:0]       va_s9, vb_s9, vc_s9;

	logic [5:0][DOTW-1:0]       dot_d9;
	logic [2:0][2:0][DIFF-1:0]  edg_d9;
	logic [2:0][2:0][CB-1:0]    cor_d9;

	logic signed [DOTW-1:0] d1, d2, d3, d4, d5, d6;
	logic signed [DOTW:0]   d43, d56;

	cpt_pkg::region_t         rg_c, rg_s10;
	logic [2:0][CB-1:0]       base_c, base_s10;
	logic [2:0][DIFF-1:0]     x1_c, x2_c, x1_s10, x2_s10;
	logic signed [VW-1:0]     y1_c, y2_c, y1_s10, y2_s10;
	logic signed [DENW-1:0]   den_c, den_s10;

	logic signed [DIFF+VW-1:0] p1_s14 [3];
	logic signed [DIFF+VW-1:0] p2_s14 [3];
	logic [DENW-1:0]           den_d14;
	logic [2:0]                rg_d14;
	logic                      dz;
	logic signed [NUMW-1:0]    num_s15 [3];
	logic signed [DENW-1:0]    den_s15;
	logic                      degen_s15;

	logic signed [QB:0]        quo [3];
	logic [2:0][CB-1:0]        base_dl;
	logic [2:0]                rg_dl;
	logic                      degen_dl;
	logic signed [SW-1:0]      sum [3];
	logic [2:0][CB-1:0]        near_q;
	logic [2:0]                region_q;
	logic                      degen_q;

	assign busy = 1'b0;

	// Advance the valid bits with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start};
		end
	end

	// Stage 1: capture the beat
	always_ff @(posedge clk) begin
		pt_s1 <= {point_z, point_y, point_x};
		ca_s1 <= {corner_a_z, corner_a_y, corner_a_x};
		cb_s1 <= {corner_b_z, corner_b_y, corner_b_x};
		cc_s1 <= {corner_c_z, corner_c_y, corner_c_x};
	end

	// Stage 2: edge and offset vectors
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			edge_s2[0][k] <= DIFF'(signed'(cb_s1[k])) - DIFF'(signed'(ca_s1[k]));
			edge_s2[1][k] <= DIFF'(signed'(cc_s1[k])) - DIFF'(signed'(ca_s1[k]));
			pv_s2[0][k]   <= DIFF'(signed'(pt_s1[k])) - DIFF'(signed'(ca_s1[k]));
			pv_s2[1][k]   <= DIFF'(signed'(pt_s1[k])) - DIFF'(signed'(cb_s1[k]));
			pv_s2[2][k]   <= DIFF'(signed'(pt_s1[k])) - DIFF'(signed'(cc_s1[k]));
			bc_s2[k]      <= DIFF'(signed'(cc_s1[k])) - DIFF'(signed'(cb_s1[k]));
		end
	end

	// Stage 3: component products of the six dot products
	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			for (int e = 0; e < 2; e++) begin
				for (int k = 0; k < 3; k++) begin
					prod_s3[j*2+e][k] <= signed'(edge_s2[e][k]) * signed'(pv_s2[j][k]);
				end
			end
		end
	end

	// Stage 4: dot products d1..d6
	always_ff @(posedge clk) begin
		for (int i = 0; i < 6; i++) begin
			dot_s4[i] <= DOTW'(signed'(prod_s3[i][0])) + DOTW'(signed'(prod_s3[i][1]))
				+ DOTW'(signed'(prod_s3[i][2]));
		end
	end

	// Cross terms for the barycentric weights
	cpt_mul #(.WA(DOTW), .WB(DOTW)) u_m0 (.clk, .a(signed'(dot_s4[0])),
		.b(signed'(dot_s4[3])), .p(m_s8[0]));
	cpt_mul #(.WA(DOTW), .WB(DOTW)) u_m1 (.clk, .a(signed'(dot_s4[2])),
		.b(signed'(dot_s4[1])), .p(m_s8[1]));
	cpt_mul #(.WA(DOTW), .WB(DOTW)) u_m2 (.clk, .a(signed'(dot_s4[4])),
		.b(signed'(dot_s4[1])), .p(m_s8[2]));
	cpt_mul #(.WA(DOTW), .WB(DOTW)) u_m3 (.clk, .a(signed'(dot_s4[0])),
		.b(signed'(dot_s4[5])), .p(m_s8[3]));
	cpt_mul #(.WA(DOTW), .WB(DOTW)) u_m4 (.clk, .a(signed'(dot_s4[2])),
		.b(signed'(dot_s4[5])), .p(m_s8[4]));
	cpt_mul #(.WA(DOTW), .WB(DOTW)) u_m5 (.clk, .a(signed'(dot_s4[4])),
		.b(signed'(dot_s4[3])), .p(m_s8[5]));

	// Stage 9: weights va, vb, vc
	always_ff @(posedge clk) begin
		vc_s9 <= VW'(m_s8[0]) - VW'(m_s8[1]);
		vb_s9 <= VW'(m_s8[2]) - VW'(m_s8[3]);
		va_s9 <= VW'(m_s8[4]) - VW'(m_s8[5]);
	end

	// Hold side data until the region decision
	cpt_dly #(.W(6*DOTW), .N(5)) u_dot_dly (.clk, .d(dot_s4), .q(dot_d9));
	cpt_dly #(.W(9*DIFF), .N(7)) u_edg_dly (.clk, .d({bc_s2, edge_s2}), .q(edg_d9));
	cpt_dly #(.W(9*CB), .N(8)) u_cor_dly (.clk, .d({cc_s1, cb_s1, ca_s1}), .q(cor_d9));

	assign d1  = signed'(dot_d9[0]);
	assign d2  = signed'(dot_d9[1]);
	assign d3  = signed'(dot_d9[2]);
	assign d4  = signed'(dot_d9[3]);
	assign d5  = signed'(dot_d9[4]);
	assign d6  = signed'(dot_d9[5]);
	assign d43 = (DOTW+1)'(d4) - (DOTW+1)'(d3);
	assign d56 = (DOTW+1)'(d5) - (DOTW+1)'(d6);

	// Classify the region and pick base, numerator terms and denominator
	always_comb begin
		rg_c   = cpt_pkg::REG_INTERIOR;
		base_c = cor_d9[0];
		x1_c   = edg_d9[0];
		y1_c   = vb_s9;
		x2_c   = edg_d9[1];
		y2_c   = vc_s9;
		den_c  = DENW'(va_s9) + DENW'(vb_s9) + DENW'(vc_s9);
		priority if (d1 <= 0 && d2 <= 0) begin
			rg_c  = cpt_pkg::REG_VERT_A;
			x1_c  = '0;
			x2_c  = '0;
			den_c = DENW'(1);
		end else if (d3 >= 0 && d4 <= d3) begin
			rg_c   = cpt_pkg::REG_VERT_B;
			base_c = cor_d9[1];
			x1_c   = '0;
			x2_c   = '0;
			den_c  = DENW'(1);
		end else if (vc_s9 <= 0 && d1 >= 0 && d3 <= 0) begin
			rg_c  = cpt_pkg::REG_EDGE_AB;
			y1_c  = VW'(d1);
			x2_c  = '0;
			den_c = DENW'(d1) - DENW'(d3);
		end else if (d6 >= 0 && d5 <= d6) begin
			rg_c   = cpt_pkg::REG_VERT_C;
			base_c = cor_d9[2];
			x1_c   = '0;
			x2_c   = '0;
			den_c  = DENW'(1);
		end else if (vb_s9 <= 0 && d2 >= 0 && d6 <= 0) begin
			rg_c  = cpt_pkg::REG_EDGE_AC;
			x1_c  = edg_d9[1];
			y1_c  = VW'(d2);
			x2_c  = '0;
			den_c = DENW'(d2) - DENW'(d6);
		end else if (va_s9 <= 0 && d43 >= 0 && d56 >= 0) begin
			rg_c   = cpt_pkg::REG_EDGE_BC;
			base_c = cor_d9[1];
			x1_c   = edg_d9[2];
			y1_c   = VW'(d43);
			x2_c   = '0;
			den_c  = DENW'(d43) + DENW'(d56);
		end else begin
			rg_c = cpt_pkg::REG_INTERIOR;
		end
	end

	// Stage 10: register the selection
	always_ff @(posedge clk) begin
		rg_s10   <= rg_c;
		base_s10 <= base_c;
		x1_s10   <= x1_c;
		x2_s10   <= x2_c;
		y1_s10   <= y1_c;
		y2_s10   <= y2_c;
		den_s10  <= den_c;
	end

	// Numerator products, two per component
	for (genvar k = 0; k < 3; k++) begin : g_num
		cpt_mul #(.WA(DIFF), .WB(VW)) u_p1 (.clk, .a(signed'(x1_s10[k])), .b(y1_s10),
			.p(p1_s14[k]));
		cpt_mul #(.WA(DIFF), .WB(VW)) u_p2 (.clk, .a(signed'(x2_s10[k])), .b(y2_s10),
			.p(p2_s14[k]));
	end

	cpt_dly #(.W(DENW), .N(4)) u_den_dly (.clk, .d(den_s10), .q(den_d14));
	cpt_dly #(.W(3), .N(4)) u_rg14_dly (.clk, .d(rg_s10), .q(rg_d14));

	assign dz = (den_d14 == '0);

	// Stage 15: sum numerators, replace a zero denominator
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			num_s15[k] <= dz ? '0 : NUMW'(p1_s14[k]) + NUMW'(p2_s14[k]);
		end
		den_s15   <= dz ? DENW'(1) : signed'(den_d14);
		degen_s15 <= dz && (rg_d14 == cpt_pkg::REG_INTERIOR);
	end

	for (genvar k = 0; k < 3; k++) begin : g_div
		cpt_div #(.NW(NUMW), .DW(DENW), .QB(QB)) u_div (.clk, .n(num_s15[k]),
			.d(den_s15), .q(quo[k]));
	end

	cpt_dly #(.W(3*CB), .N(5+L)) u_base_dly (.clk, .d(base_s10), .q(base_dl));
	cpt_dly #(.W(3), .N(5+L)) u_rg_dly (.clk, .d(rg_s10), .q(rg_dl));
	cpt_dly #(.W(1), .N(L)) u_dg_dly (.clk, .d(degen_s15), .q(degen_dl));

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sum[k] = SW'(signed'(base_dl[k])) + SW'(quo[k]);
		end
	end

	// Output stage: add offset to base and saturate
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			if (sum[k] > MAXV) begin
				near_q[k] <= MAXV[CB-1:0];
			end else if (sum[k] < MINV) begin
				near_q[k] <= MINV[CB-1:0];
			end else begin
				near_q[k] <= sum[k][CB-1:0];
			end
		end
		region_q <= rg_dl;
		degen_q  <= degen_dl;
	end

	assign done       = vld_q[LAT-1];
	assign near_x     = signed'(near_q[0]);
	assign near_y     = signed'(near_q[1]);
	assign near_z     = signed'(near_q[2]);
	assign region     = region_q;
	assign degenerate = degen_q;

endmodule

FILE: src/cpt_chk.sv
module cpt_chk #(
	parameter int COORD_BITS = 24
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic signed [COORD_BITS-1:0] corner_a_x,
	input logic signed [COORD_BITS-1:0] corner_a_y,
	input logic                         done,
	input logic signed [COORD_BITS-1:0] near_x,
	input logic signed [COORD_BITS-1:0] near_y,
	input logic [2:0]                   region,
	input logic                         degenerate
);

	localparam int LAT = cpt_pkg::pipe_latency(COORD_BITS);

	// Every done beat answers a start issued a fixed latency earlier
	a_done_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("done without matching start");

	// A zero interior denominator is only reported in the interior region
	a_degen_region: assert property (@(posedge clk) disable iff (!arst_n)
		done && degenerate |-> region == cpt_pkg::REG_INTERIOR)
		else $error("degenerate flag outside interior region");

	// Degenerate and vertex a results return corner a
	a_degen_corner: assert property (@(posedge clk) disable iff (!arst_n)
		done && (degenerate || region == cpt_pkg::REG_VERT_A) |->
			near_x == $past(corner_a_x, LAT) && near_y == $past(corner_a_y, LAT))
		else $error("corner a not returned");

	// The unit never holds off a query
	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy)
		else $error("busy raised");

endmodule

bind closest_point_on_triangle_unit cpt_chk #(.COORD_BITS(COORD_BITS)) u_cpt_chk (
	.clk, .arst_n, .start, .busy, .corner_a_x, .corner_a_y,
	.done, .near_x, .near_y, .region, .degenerate
);
